// ===== design/mbns_pkg.sv =====
// ---------------------------------------------------------------------------
// mbns_pkg
// Shared types and constants for the one-bit-per-pixel nearest scaler:
// sequencer states, opcodes, register indexes and fast-path step factors.
// ---------------------------------------------------------------------------
`default_nettype none

package mbns_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // transaction opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // configuration register indexes (byte address is 4 * index)
  localparam int          APB_ADDR_W  = 5;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SRC_LEFT   = 3'd4;
  localparam logic [2:0] REG_DST_LEFT   = 3'd5;
  localparam logic [2:0] REG_X_FACTOR   = 3'd6;
  localparam logic [2:0] REG_Y_FACTOR   = 3'd7;

  // 10.16 steps that reproduce the exact 2x paths: half and double
  localparam logic [25:0] STEP_HALF   = 26'h000_8000;
  localparam logic [25:0] STEP_DOUBLE = 26'h002_0000;
  localparam logic [25:0] STEP_UNITY  = 26'h001_0000;

  // multiplier operand and product widths
  localparam int MUL_A_W = 9;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int INT_W   = PROD_W - 16;

endpackage

`default_nettype wire

// ===== design/mono_bitmap_nearest_scaler.sv =====
// ---------------------------------------------------------------------------
// mono_bitmap_nearest_scaler
// Nearest-neighbor scaler for 1bpp bitmaps with a single-port source frame
// store and one shared multiplier stepped by a small sequencer.
// ---------------------------------------------------------------------------
// A write transaction (op = 0) stores one source byte in the frame store in
// the cycle it is taken; busy stays low. A read transaction (op = 1) yields
// one result on done. A read that samples pixels holds busy through
// one multiplier pass for the source row, then eight passes for the pixel
// columns, each followed by one read of the single-port frame store and the
// registered read return, then the forming of the byte. A read whose row
// is past dst_height, or whose byte lies wholly past dst_width, holds busy
// for one cycle. In both cases done rises at the same edge at which busy
// falls. done is a one-cycle strobe and the receiver cannot stall it; a new
// transaction may be started while the previous result is shown. The frame
// store has no reset and is not cleared.
`default_nettype none

module mono_bitmap_nearest_scaler #(
  parameter int MAX_ROWS  = 256,
  parameter int ROW_BYTES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command channel
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             op,
  input  wire logic [7:0]                       row,
  input  wire logic [5:0]                       byte_col,
  input  wire logic [7:0]                       data,
  input  wire logic [7:0]                       prior,
  // result channel
  output      logic                             done,
  output      logic [7:0]                       dest_byte,
  output      logic                             replaced,
  output      logic                             out_of_range,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mbns_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output      logic [31:0]                      prdata,
  output      logic                             pready
);

  localparam int DEPTH = MAX_ROWS * ROW_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int IW    = mbns_pkg::INT_W;
  localparam int SCW   = IW + 1;
  localparam logic [IW-1:0]  MaxRowsW  = IW'(MAX_ROWS);
  localparam logic [SCW-4:0] RowBytesW = (SCW - 3)'(ROW_BYTES);

  // configuration registers
  logic [9:0]  src_width;
  logic [8:0]  src_height;
  logic [9:0]  dst_width;
  logic [8:0]  dst_height;
  logic [8:0]  src_left;
  logic [8:0]  dst_left;
  logic [25:0] x_factor;
  logic [24:0] y_factor;

  // sequencer and item registers
  mbns_pkg::state_t state, state_next;
  logic [3:0]  cnt;
  logic [7:0]  row_q;
  logic [5:0]  col_q;
  logic [7:0]  prior_q;
  logic        oor_q;
  logic        fast_q;

  // datapath registers
  logic [mbns_pkg::PROD_W-1:0] prod;
  logic [IW-1:0]               srow;
  logic                        rd_live;
  logic                        rd_ok;
  logic [2:0]                  rd_sel;
  logic [7:0]                  rdata;
  logic [7:0]                  bits;

  logic [7:0] mem [DEPTH];

  // combinational helpers
  logic                        accept;
  logic                        aligned, stretch, squish;
  logic [25:0]                 xf_eff;
  logic [25:0]                 yf_eff;
  logic [mbns_pkg::MUL_A_W-1:0] mul_a;
  logic [mbns_pkg::MUL_B_W-1:0] mul_b;
  logic [2:0]                  pix_idx;
  logic [SCW-1:0]              scol;
  logic                        issue;
  logic                        wr_in_range;
  logic                        rd_in_range;
  logic                        row_oor;
  logic                        byte_past;
  logic [7:0]                  mask;
  logic [7:0]                  result;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r,
                                            input logic [SCW-4:0] b);
    addr_of = AW'(r[RW-1:0]) * AW'(ROW_BYTES) + AW'(b[CW-1:0]);
  endfunction

  assign accept = start && !busy;
  assign pready = 1'b1;

  // fast-path detection from the current configuration
  always_comb begin
    aligned = (src_left[2:0] | dst_left[2:0] | src_width[2:0] | dst_width[2:0]) == 3'd0;
    stretch = aligned && ({1'b0, dst_width} == {src_width, 1'b0}) &&
              ({1'b0, dst_height} == {src_height, 1'b0});
    squish  = !stretch && aligned && ({1'b0, src_width} == {dst_width, 1'b0}) &&
              ({1'b0, src_height} == {dst_height, 1'b0});
    if (stretch) begin
      xf_eff = mbns_pkg::STEP_HALF;
      yf_eff = mbns_pkg::STEP_HALF;
    end else if (squish) begin
      xf_eff = mbns_pkg::STEP_DOUBLE;
      yf_eff = mbns_pkg::STEP_DOUBLE;
    end else begin
      xf_eff = x_factor;
      yf_eff = {1'b0, y_factor};
    end
  end

  // early-exit checks and the write range check on the incoming transaction
  assign row_oor     = {1'b0, row} >= dst_height;
  assign byte_past   = {1'b0, byte_col, 3'b000} >= dst_width;
  assign wr_in_range = (IW'(row) < MaxRowsW) && ((SCW - 3)'(byte_col) < RowBytesW);

  // shared multiplier operands: row pass first, then one pixel per pass
  assign pix_idx = 3'(cnt - 4'd1);
  always_comb begin
    if (cnt == 4'd0) begin
      mul_a = {1'b0, row_q};
      mul_b = yf_eff;
    end else begin
      mul_a = {col_q, pix_idx};
      mul_b = xf_eff;
    end
  end

  // source column of the pixel whose product is in prod
  assign scol        = SCW'(src_left) + SCW'(prod[mbns_pkg::PROD_W-1:16]);
  assign issue       = (state == mbns_pkg::ST_RUN) && (cnt >= 4'd2) && (cnt <= 4'd9);
  assign rd_in_range = (srow < MaxRowsW) && (scol[SCW-1:3] < RowBytesW);

  // pixels of the byte that lie inside the destination width
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[7-i] = {1'b0, col_q, 3'(i)} < dst_width;
    end
  end

  // final byte
  always_comb begin
    if (fast_q) begin
      result = (prior_q & ~mask) | (bits & mask);
    end else begin
      result = prior_q | (bits & mask);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mbns_pkg::ST_IDLE: begin
        if (accept && op == mbns_pkg::OP_READ) begin
          state_next = (row_oor || byte_past) ? mbns_pkg::ST_FINISH : mbns_pkg::ST_RUN;
        end
      end
      mbns_pkg::ST_RUN: begin
        if (cnt == 4'd10) begin
          state_next = mbns_pkg::ST_FINISH;
        end
      end
      mbns_pkg::ST_FINISH: state_next = mbns_pkg::ST_IDLE;
      default:             state_next = mbns_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    case (state)
      mbns_pkg::ST_IDLE: busy = 1'b0;
      default:           busy = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbns_pkg::ST_IDLE;
      cnt   <= 4'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == mbns_pkg::ST_FINISH);
      if (state == mbns_pkg::ST_RUN) begin
        cnt <= cnt + 4'd1;
      end else begin
        cnt <= 4'd0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q   <= row;
      col_q   <= byte_col;
      prior_q <= prior;
      oor_q   <= row_oor;
      fast_q  <= stretch || squish;
    end
  end

  // multiplier pass and pixel pipeline
  always_ff @(posedge clk) begin
    prod <= mbns_pkg::PROD_W'(mul_a) * mbns_pkg::PROD_W'(mul_b);
    if (state == mbns_pkg::ST_RUN && cnt == 4'd1) begin
      srow <= prod[mbns_pkg::PROD_W-1:16];
    end
    rd_live <= issue;
    rd_ok   <= rd_in_range;
    rd_sel  <= scol[2:0];
    if (rd_live) begin
      bits <= {bits[6:0], rd_ok ? rdata[3'd7 - rd_sel] : 1'b0};
    end
  end

  // frame store: one access per cycle
  always_ff @(posedge clk) begin
    if (accept && op == mbns_pkg::OP_WRITE) begin
      if (wr_in_range) begin
        mem[addr_of(IW'(row), (SCW - 3)'(byte_col))] <= data;
      end
    end else if (issue) begin
      rdata <= mem[addr_of(srow, scol[SCW-1:3])];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == mbns_pkg::ST_FINISH) begin
      out_of_range <= oor_q;
      if (oor_q || mask == 8'd0) begin
        dest_byte <= prior_q;
        replaced  <= 1'b0;
      end else begin
        dest_byte <= result;
        replaced  <= fast_q;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 10'd1;
      src_height <= 9'd1;
      dst_width  <= 10'd1;
      dst_height <= 9'd1;
      src_left   <= 9'd0;
      dst_left   <= 9'd0;
      x_factor   <= mbns_pkg::STEP_UNITY;
      y_factor   <= 25'(mbns_pkg::STEP_UNITY);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        mbns_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[9:0];
        mbns_pkg::REG_SRC_HEIGHT: src_height <= pwdata[8:0];
        mbns_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[9:0];
        mbns_pkg::REG_DST_HEIGHT: dst_height <= pwdata[8:0];
        mbns_pkg::REG_SRC_LEFT:   src_left   <= pwdata[8:0];
        mbns_pkg::REG_DST_LEFT:   dst_left   <= pwdata[8:0];
        mbns_pkg::REG_X_FACTOR:   x_factor   <= pwdata[25:0];
        mbns_pkg::REG_Y_FACTOR:   y_factor   <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[4:2])
      mbns_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width);
      mbns_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height);
      mbns_pkg::REG_DST_WIDTH:  prdata = 32'(dst_width);
      mbns_pkg::REG_DST_HEIGHT: prdata = 32'(dst_height);
      mbns_pkg::REG_SRC_LEFT:   prdata = 32'(src_left);
      mbns_pkg::REG_DST_LEFT:   prdata = 32'(dst_left);
      mbns_pkg::REG_X_FACTOR:   prdata = 32'(x_factor);
      mbns_pkg::REG_Y_FACTOR:   prdata = 32'(y_factor);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire
